// File: rtl/dcga_pkg.sv
// ----------------------------------------------------------------------------
// dcga_pkg
// Shared types, constants and helpers of the Coulomb grid accumulator.
// ----------------------------------------------------------------------------
package dcga_pkg;

	localparam int GRID_POINTS_DEF = 4096;
	localparam int MAX_DIM_DEF     = 64;

	localparam int IN_DATA_W  = 168;
	localparam int OUT_DATA_W = 64;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Index width that holds any linear grid index for range compares.
	localparam int IDX_W  = 17;
	// Signed width of a point coordinate or an offset.
	localparam int POS_W  = 42;
	localparam int MAG_W  = 42;
	localparam int DIST_W = 43;
	localparam int NUM_W  = 56;
	localparam int ACC_W  = 48;

	localparam logic signed [ACC_W-1:0] ACC_MAX = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [ACC_W-1:0] ACC_MIN = 48'sh8000_0000_0000;
	localparam logic [NUM_W-1:0] QUO_LIM_POS = 56'h00_7FFF_FFFF_FFFF;
	localparam logic [NUM_W-1:0] QUO_LIM_NEG = 56'h00_8000_0000_0000;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_ACC   = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	localparam logic [CFG_IDX_W-1:0] REG_STEP_X   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_Y   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DIR      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_NX       = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_NY       = 3'd7;

	localparam logic [1:0] DIR_Z    = 2'd0;
	localparam logic [1:0] DIR_Y    = 2'd1;
	localparam logic [1:0] DIR_X    = 2'd2;
	localparam logic [1:0] DIR_NONE = 2'd3;

	typedef struct packed {
		op_t                op;
		logic signed [31:0] src_x;
		logic signed [31:0] src_y;
		logic signed [31:0] src_z;
		logic signed [31:0] charge;
		logic [5:0]         x_lo;
		logic [5:0]         x_hi;
		logic [5:0]         y_lo;
		logic [5:0]         y_hi;
		logic [11:0]        point_index;
	} item_t;

	typedef struct packed {
		logic [30:0]        step_x;
		logic [30:0]        step_y;
		logic signed [31:0] origin_x;
		logic signed [31:0] origin_y;
		logic signed [31:0] plane;
		logic [1:0]         dir;
		logic [6:0]         nx;
		logic [6:0]         ny;
	} cfg_t;

	typedef struct packed {
		logic init_busy;
		logic take;
	} back_status_t;

	typedef enum logic [11:0] {
		ST_CLR   = 12'h001,
		ST_IDLE  = 12'h002,
		ST_PT    = 12'h004,
		ST_DIFF  = 12'h008,
		ST_SHIFT = 12'h010,
		ST_SQ    = 12'h020,
		ST_SQRT  = 12'h040,
		ST_DIV   = 12'h080,
		ST_MRD   = 12'h100,
		ST_MWR   = 12'h200,
		ST_RRD   = 12'h400,
		ST_ROUT  = 12'h800
	} state_t;

	function automatic logic signed [POS_W-1:0] sext_pos(input logic [31:0] v);
		return {{(POS_W-32){v[31]}}, v};
	endfunction

endpackage

// File: rtl/dcga_front.sv
// ----------------------------------------------------------------------------
// dcga_front
// Accepts input transactions, decodes them and queues the useful ones.
// ----------------------------------------------------------------------------
module dcga_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// src_x, src_y, src_z, charge, x_lo, x_hi, y_lo, y_hi, point_index, zero pad
	input  logic [dcga_pkg::IN_DATA_W-1:0] s_tdata,
	// op
	input  logic [1:0]                     s_tuser,
	output logic                           q_valid,
	output dcga_pkg::item_t                q_item,
	input  dcga_pkg::back_status_t         status
);
	import dcga_pkg::*;

	localparam int DEPTH = 2;

	item_t      fifo_q [DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	item_t      in_item;
	logic       accept;
	logic       push;
	logic       pop;

	always_comb begin
		in_item.op          = op_t'(s_tuser);
		in_item.src_x       = s_tdata[31:0];
		in_item.src_y       = s_tdata[63:32];
		in_item.src_z       = s_tdata[95:64];
		in_item.charge      = s_tdata[127:96];
		in_item.x_lo        = s_tdata[133:128];
		in_item.x_hi        = s_tdata[139:134];
		in_item.y_lo        = s_tdata[145:140];
		in_item.y_hi        = s_tdata[151:146];
		in_item.point_index = s_tdata[163:152];
	end

	assign s_tready = (cnt_q != 2'(DEPTH)) && !status.init_busy;
	assign accept   = s_tvalid && s_tready;
	// An unused op code is taken and dropped here.
	assign push     = accept && (in_item.op != OP_NONE);
	assign q_valid  = cnt_q != 2'd0;
	assign q_item   = fifo_q[rd_ptr_q];
	assign pop      = q_valid && status.take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				fifo_q[wr_ptr_q] <= in_item;
				wr_ptr_q         <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'(DEPTH))
		else $error("queue count exceeds depth");

endmodule

// File: rtl/dcga_back.sv
// ----------------------------------------------------------------------------
// dcga_back
// Sequencer over the potential store: clears, accumulates and reads entries.
// ----------------------------------------------------------------------------
module dcga_back #(
	parameter int GRID_POINTS = dcga_pkg::GRID_POINTS_DEF,
	parameter int MAX_DIM     = dcga_pkg::MAX_DIM_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            q_valid,
	input  dcga_pkg::item_t                 q_item,
	input  dcga_pkg::cfg_t                  cfg,
	output dcga_pkg::back_status_t          status,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// potential, read_index, zero pad
	output logic [dcga_pkg::OUT_DATA_W-1:0] m_tdata
);
	import dcga_pkg::*;

	localparam int AW = $clog2(GRID_POINTS);
	localparam logic [8:0] MAX_DIM_L = 9'(MAX_DIM);

	state_t                   state_q;
	logic                     init_q;
	logic [AW-1:0]            clr_cnt_q;
	item_t                    item_q;
	logic [5:0]               ix_q;
	logic [5:0]               iy_q;
	logic [5:0]               step_q;
	logic signed [POS_W-1:0]  u_q;
	logic signed [POS_W-1:0]  v_q;
	logic [IDX_W-1:0]         nn_q;
	logic [MAG_W-1:0]         ax_q, ay_q, az_q;
	logic [30:0]              sh_q [3];
	logic [3:0]               shamt_q;
	logic [63:0]              sum_q;
	logic [63:0]              rad_q;
	logic [33:0]              rem_sq_q;
	logic [31:0]              root_q;
	logic [DIST_W-1:0]        dist_q;
	logic                     zero_dist_q;
	logic [NUM_W-1:0]         num_q;
	logic [DIST_W-1:0]        rem_q;
	logic [NUM_W-1:0]         quo_q;
	logic signed [ACC_W-1:0]  contrib_q;
	logic [ACC_W-1:0]         rdata_q;
	logic                     rd_ok_q;
	logic                     out_valid_q;
	logic [ACC_W-1:0]         out_pot_q;
	logic [11:0]              out_idx_q;
	logic [ACC_W-1:0]         potential_q [GRID_POINTS];

	logic [8:0]               nx_lim, ny_lim;
	logic [IDX_W-1:0]         nn_c;
	logic [IDX_W-1:0]         rd_idx;
	logic                     skip_c;
	logic [POS_W-1:0]         ustep, vstep;
	logic signed [POS_W-1:0]  u_c, v_c;
	logic signed [POS_W-1:0]  px, py, pz, dx, dy, dz;
	logic [MAG_W-1:0]         m_c;
	logic [3:0]               shamt_c;
	logic [30:0]              sq_sel;
	logic [61:0]              prod;
	logic [33:0]              sq_in, sq_trial, sq_rem_n;
	logic                     sq_ge;
	logic [31:0]              root_n;
	logic [DIST_W:0]          dv_trial;
	logic                     dv_ge;
	logic [31:0]              qmag;
	logic signed [ACC_W-1:0]  contrib_c;
	logic signed [ACC_W:0]    acc_sum;
	logic signed [ACC_W-1:0]  acc_sat;
	logic                     row_end, last_pt;
	logic                     mem_we, mem_re;
	logic [AW-1:0]            mem_waddr, mem_raddr;
	logic [ACC_W-1:0]         mem_wdata;
	logic                     out_load;

	// Grid limits and linear index of the current point.
	always_comb begin
		nx_lim = (9'(cfg.nx) < MAX_DIM_L) ? 9'(cfg.nx) : MAX_DIM_L;
		ny_lim = (9'(cfg.ny) < MAX_DIM_L) ? 9'(cfg.ny) : MAX_DIM_L;
		nn_c   = IDX_W'(ix_q) * IDX_W'(ny_lim) + IDX_W'(iy_q);
		skip_c = (9'(ix_q) >= nx_lim) || (9'(iy_q) >= ny_lim)
			|| (nn_c >= IDX_W'(GRID_POINTS));
		ustep  = POS_W'(ix_q) * POS_W'(cfg.step_x);
		vstep  = POS_W'(iy_q) * POS_W'(cfg.step_y);
		u_c    = sext_pos(cfg.origin_x) + signed'(ustep);
		v_c    = sext_pos(cfg.origin_y) + signed'(vstep);
		rd_idx = IDX_W'(item_q.point_index);
	end

	// Offsets from the source to the grid point.
	always_comb begin
		case (cfg.dir)
			DIR_Y: begin
				px = u_q;
				py = sext_pos(cfg.plane);
				pz = v_q;
			end
			DIR_X: begin
				px = sext_pos(cfg.plane);
				py = u_q;
				pz = v_q;
			end
			default: begin
				px = u_q;
				py = v_q;
				pz = sext_pos(cfg.plane);
			end
		endcase
		dx = px - sext_pos(item_q.src_x);
		dy = py - sext_pos(item_q.src_y);
		dz = pz - sext_pos(item_q.src_z);
	end

	// Shift that brings the largest magnitude below 2^31.
	always_comb begin
		m_c = ax_q;
		if (ay_q > m_c) begin
			m_c = ay_q;
		end
		if (az_q > m_c) begin
			m_c = az_q;
		end
		shamt_c = 4'd0;
		for (int k = 0; k < MAG_W - 31; k++) begin
			if (m_c[31+k]) begin
				shamt_c = 4'(k + 1);
			end
		end
	end

	// One square per cycle into the running sum.
	always_comb begin
		case (step_q[1:0])
			2'd1:    sq_sel = sh_q[1];
			2'd2:    sq_sel = sh_q[2];
			default: sq_sel = sh_q[0];
		endcase
		prod = 62'(sq_sel) * 62'(sq_sel);
	end

	// Restoring square root, one result bit per cycle.
	always_comb begin
		sq_in    = {rem_sq_q[31:0], rad_q[63:62]};
		sq_trial = {root_q, 2'b01};
		sq_ge    = sq_in >= sq_trial;
		sq_rem_n = sq_ge ? (sq_in - sq_trial) : sq_in;
		root_n   = {root_q[30:0], sq_ge};
	end

	// Restoring division, one quotient bit per cycle.
	always_comb begin
		dv_trial = {rem_q, num_q[NUM_W-1]};
		dv_ge    = dv_trial >= {1'b0, dist_q};
		qmag     = item_q.charge[31] ? 32'(-{item_q.charge[31], item_q.charge})
			: item_q.charge;
	end

	// Signed, saturated contribution and saturating update of the entry.
	always_comb begin
		if (zero_dist_q) begin
			if (item_q.charge == 32'sd0) begin
				contrib_c = '0;
			end else if (item_q.charge[31]) begin
				contrib_c = ACC_MIN;
			end else begin
				contrib_c = ACC_MAX;
			end
		end else if (item_q.charge[31]) begin
			contrib_c = (quo_q > QUO_LIM_NEG) ? ACC_MIN : -signed'(quo_q[ACC_W-1:0]);
		end else begin
			contrib_c = (quo_q > QUO_LIM_POS) ? ACC_MAX : signed'(quo_q[ACC_W-1:0]);
		end
		acc_sum = {rdata_q[ACC_W-1], rdata_q} + {contrib_q[ACC_W-1], contrib_q};
		if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
			acc_sat = acc_sum[ACC_W] ? ACC_MIN : ACC_MAX;
		end else begin
			acc_sat = acc_sum[ACC_W-1:0];
		end
	end

	assign row_end = iy_q == item_q.y_hi;
	assign last_pt = row_end && (ix_q == item_q.x_hi);

	assign mem_we    = (state_q == ST_CLR) || (state_q == ST_MWR);
	assign mem_waddr = (state_q == ST_CLR) ? clr_cnt_q : nn_q[AW-1:0];
	assign mem_wdata = (state_q == ST_CLR) ? '0 : acc_sat;
	assign mem_re    = (state_q == ST_MRD) || (state_q == ST_RRD);
	assign mem_raddr = (state_q == ST_RRD) ? rd_idx[AW-1:0] : nn_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			potential_q[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= potential_q[mem_raddr];
		end
	end

	assign out_load         = (state_q == ST_ROUT) && (!out_valid_q || m_tready);
	assign status.take      = state_q == ST_IDLE;
	assign status.init_busy = init_q;
	assign m_tvalid         = out_valid_q;
	assign m_tdata          = {4'd0, out_idx_q, out_pot_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			init_q      <= 1'b1;
			clr_cnt_q   <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
				out_pot_q   <= rd_ok_q ? rdata_q : '0;
				out_idx_q   <= item_q.point_index;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == AW'(GRID_POINTS - 1)) begin
						clr_cnt_q <= '0;
						init_q    <= 1'b0;
						state_q   <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (q_valid) begin
						item_q <= q_item;
						ix_q   <= q_item.x_lo;
						iy_q   <= q_item.y_lo;
						case (q_item.op)
							OP_CLEAR: state_q <= ST_CLR;
							OP_ACC: begin
								if (cfg.dir != DIR_NONE && q_item.x_lo <= q_item.x_hi
									&& q_item.y_lo <= q_item.y_hi) begin
									state_q <= ST_PT;
								end
							end
							OP_READ: state_q <= ST_RRD;
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_PT: begin
					u_q  <= u_c;
					v_q  <= v_c;
					nn_q <= nn_c;
					if (!skip_c) begin
						state_q <= ST_DIFF;
					end else if (last_pt) begin
						state_q <= ST_IDLE;
					end else if (row_end) begin
						ix_q <= ix_q + 6'd1;
						iy_q <= item_q.y_lo;
					end else begin
						iy_q <= iy_q + 6'd1;
					end
				end
				ST_DIFF: begin
					ax_q    <= dx[POS_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
					ay_q    <= dy[POS_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
					az_q    <= dz[POS_W-1] ? MAG_W'(-dz) : MAG_W'(dz);
					state_q <= ST_SHIFT;
				end
				ST_SHIFT: begin
					sh_q[0] <= 31'(ax_q >> shamt_c);
					sh_q[1] <= 31'(ay_q >> shamt_c);
					sh_q[2] <= 31'(az_q >> shamt_c);
					shamt_q <= shamt_c;
					sum_q   <= '0;
					step_q  <= '0;
					state_q <= ST_SQ;
				end
				ST_SQ: begin
					sum_q  <= sum_q + 64'(prod);
					step_q <= step_q + 6'd1;
					if (step_q == 6'd2) begin
						step_q  <= '0;
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					if (step_q == 6'd0) begin
						rad_q    <= sum_q;
						rem_sq_q <= '0;
						root_q   <= '0;
						step_q   <= 6'd1;
					end else begin
						rad_q    <= rad_q << 2;
						rem_sq_q <= sq_rem_n;
						root_q   <= root_n;
						step_q   <= step_q + 6'd1;
						if (step_q == 6'd32) begin
							dist_q      <= DIST_W'(root_n) << shamt_q;
							zero_dist_q <= root_n == 32'd0;
							num_q       <= NUM_W'(qmag) << 24;
							rem_q       <= '0;
							quo_q       <= '0;
							step_q      <= '0;
							state_q     <= (root_n == 32'd0) ? ST_MRD : ST_DIV;
						end
					end
				end
				ST_DIV: begin
					rem_q  <= dv_ge ? DIST_W'(dv_trial - {1'b0, dist_q}) : DIST_W'(dv_trial);
					quo_q  <= {quo_q[NUM_W-2:0], dv_ge};
					num_q  <= num_q << 1;
					step_q <= step_q + 6'd1;
					if (step_q == 6'(NUM_W - 1)) begin
						step_q  <= '0;
						state_q <= ST_MRD;
					end
				end
				ST_MRD: begin
					contrib_q <= contrib_c;
					state_q   <= ST_MWR;
				end
				ST_MWR: begin
					if (last_pt) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_PT;
						if (row_end) begin
							ix_q <= ix_q + 6'd1;
							iy_q <= item_q.y_lo;
						end else begin
							iy_q <= iy_q + 6'd1;
						end
					end
				end
				ST_RRD: begin
					rd_ok_q <= rd_idx < IDX_W'(GRID_POINTS);
					state_q <= ST_ROUT;
				end
				ST_ROUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_init_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		init_q |-> state_q == ST_CLR)
		else $error("reset clearing pass left the clear state early");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MRD && !zero_dist_q) |-> rem_q < dist_q)
		else $error("division remainder not below divisor");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MWR |-> nn_q < IDX_W'(GRID_POINTS))
		else $error("store update outside the grid");

	a_sqrt_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SQ && step_q == 6'd2) |=> (state_q == ST_SQRT && step_q == 6'd0))
		else $error("square root started with a stale step count");

endmodule

// File: rtl/direct_coulomb_grid_accumulator_core.sv
// A read goes through the store read state and the output state, which waits
// for a free output register before m_tvalid rises. An accumulate takes the
// in-grid points of its rectangle in turn, each through the offset, shift, square,
// bit-serial square root and divider states (no divide at zero distance); off-grid
// points are skipped. The next queued item is taken only when idle. A clear zeroes
// the store; the reset sweep zeroes it too, with no input transaction accepted.
// ----------------------------------------------------------------------------
// direct_coulomb_grid_accumulator_core
// Planar grid of Coulomb potentials with a decoded front queue and a sequencer.
// ----------------------------------------------------------------------------
module direct_coulomb_grid_accumulator_core #(
	parameter int GRID_POINTS = dcga_pkg::GRID_POINTS_DEF,
	parameter int MAX_DIM     = dcga_pkg::MAX_DIM_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// src_x, src_y, src_z, charge, x_lo, x_hi, y_lo, y_hi, point_index, zero pad
	input  logic [dcga_pkg::IN_DATA_W-1:0]  s_tdata,
	// op
	input  logic [1:0]                      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// potential, read_index, zero pad
	output logic [dcga_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [dcga_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dcga_pkg::CFG_DATA_W-1:0] cfg_data
);
	import dcga_pkg::*;

	cfg_t         cfg_q;
	logic         q_valid;
	item_t        q_item;
	back_status_t status;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_x   <= 31'd65536;
			cfg_q.step_y   <= 31'd65536;
			cfg_q.origin_x <= '0;
			cfg_q.origin_y <= '0;
			cfg_q.plane    <= '0;
			cfg_q.dir      <= DIR_Z;
			cfg_q.nx       <= 7'd64;
			cfg_q.ny       <= 7'd64;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_STEP_X:   cfg_q.step_x   <= cfg_data[30:0];
				REG_STEP_Y:   cfg_q.step_y   <= cfg_data[30:0];
				REG_ORIGIN_X: cfg_q.origin_x <= cfg_data;
				REG_ORIGIN_Y: cfg_q.origin_y <= cfg_data;
				REG_PLANE:    cfg_q.plane    <= cfg_data;
				REG_DIR:      cfg_q.dir      <= cfg_data[1:0];
				REG_NX:       cfg_q.nx       <= cfg_data[6:0];
				REG_NY:       cfg_q.ny       <= cfg_data[6:0];
				default:      cfg_q.dir      <= cfg_q.dir;
			endcase
		end
	end

	dcga_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.status   (status)
	);

	dcga_back #(
		.GRID_POINTS (GRID_POINTS),
		.MAX_DIM     (MAX_DIM)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.cfg      (cfg_q),
		.status   (status),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
